FILE: hdl/trva_pkg.sv
// ---------------------------------------------------------------------------
// trva_pkg
// Shared widths, codes, state encoding and inter-module structs for the
// tick range VWAP aggregator.
// ---------------------------------------------------------------------------
package trva_pkg;

	localparam int TsW     = 64;
	localparam int PriceW  = 32;
	localparam int VolW    = 32;
	localparam int CountW  = 32;
	localparam int SumW    = 64;
	localparam int DivW    = 64;
	localparam int DivCntW = $clog2(DivW);
	localparam int CfgIdxW = 1;
	localparam int CfgW    = 64;
	localparam int InDataW = TsW + PriceW + VolW;
	localparam int OutDataW = CountW + SumW + 4 * PriceW;

	// register indexes on the config port
	localparam logic [CfgIdxW-1:0] CFG_RANGE_START = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_RANGE_END   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_VWAP_GO,
		ST_VWAP_WAIT,
		ST_EMIT
	} trva_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic clear;
	} acc_ctl_t;

	typedef struct packed {
		logic [CountW-1:0] match_count;
		logic [SumW-1:0]   volume_sum;
		logic [SumW-1:0]   price_sum;
		logic [SumW-1:0]   weighted_sum;
		logic [PriceW-1:0] min_seen;
		logic [PriceW-1:0] max_seen;
		logic              first_pending;
	} acc_state_t;

	// accumulators empty, no tick matched yet
	localparam acc_state_t ACC_CLEAR = '{
		match_count:   '0,
		volume_sum:    '0,
		price_sum:     '0,
		weighted_sum:  '0,
		min_seen:      '0,
		max_seen:      '0,
		first_pending: 1'b1
	};

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// clamp a 64-bit quotient into the 32-bit price format
	function automatic logic [PriceW-1:0] sat_price(input logic [DivW-1:0] v);
		logic [PriceW-1:0] r;
		r = (|v[DivW-1:PriceW]) ? '1 : v[PriceW-1:0];
		return r;
	endfunction

endpackage

FILE: hdl/trva_div.sv
// ---------------------------------------------------------------------------
// trva_div
// Shared restoring divider, one quotient bit per cycle, 64 steps.
// ---------------------------------------------------------------------------
module trva_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [trva_pkg::DivW-1:0] dividend,
	input  logic [trva_pkg::DivW-1:0] divisor,
	output logic [trva_pkg::DivW-1:0] quotient,
	output trva_pkg::div_stat_t       status
);

	logic [trva_pkg::DivW-1:0]    rem_q;
	logic [trva_pkg::DivW-1:0]    quo_q;
	logic [trva_pkg::DivW-1:0]    dsr_q;
	logic [trva_pkg::DivCntW-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [trva_pkg::DivW:0] rem_sh;
	logic [trva_pkg::DivW:0] rem_sub;
	logic                    q_bit;

	always_comb begin
		rem_sh  = {rem_q, quo_q[trva_pkg::DivW-1]};
		q_bit   = (rem_sh >= {1'b0, dsr_q});
		rem_sub = q_bit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == trva_pkg::DivCntW'(trva_pkg::DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_sub[trva_pkg::DivW-1:0];
			quo_q <= {quo_q[trva_pkg::DivW-2:0], q_bit};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

FILE: hdl/trva_accum.sv
// ---------------------------------------------------------------------------
// trva_accum
// Window filter, price x volume product and saturating accumulators.
// ---------------------------------------------------------------------------
module trva_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trva_pkg::acc_ctl_t          ctl,
	input  logic [trva_pkg::TsW-1:0]    timestamp,
	input  logic [trva_pkg::PriceW-1:0] price,
	input  logic [trva_pkg::VolW-1:0]   volume,
	input  logic [trva_pkg::TsW-1:0]    range_start,
	input  logic [trva_pkg::TsW-1:0]    range_end,
	output trva_pkg::acc_state_t        acc
);

	logic [trva_pkg::TsW-1:0]    ts_q;
	logic [trva_pkg::PriceW-1:0] price_q;
	logic [trva_pkg::VolW-1:0]   vol_q;
	logic                        hit_q;
	logic [trva_pkg::SumW-1:0]   prod_q;
	trva_pkg::acc_state_t        acc_q;

	logic [trva_pkg::SumW:0] vol_add;
	logic [trva_pkg::SumW:0] price_add;
	logic [trva_pkg::SumW:0] wsum_add;

	always_comb begin
		vol_add   = {1'b0, acc_q.volume_sum} + {1'b0, 32'b0, vol_q};
		price_add = {1'b0, acc_q.price_sum} + {1'b0, 32'b0, price_q};
		wsum_add  = {1'b0, acc_q.weighted_sum} + {1'b0, prod_q};
	end

	// tick capture and product stage
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ts_q    <= timestamp;
			price_q <= price;
			vol_q   <= volume;
		end
		if (ctl.mul) begin
			// an empty window (start > end) can never satisfy both compares
			hit_q  <= (ts_q >= range_start) && (ts_q <= range_end);
			prod_q <= trva_pkg::SumW'(price_q) * trva_pkg::SumW'(vol_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= trva_pkg::ACC_CLEAR;
		end else if (ctl.clear) begin
			acc_q <= trva_pkg::ACC_CLEAR;
		end else if (ctl.add && hit_q) begin
			if (acc_q.match_count != '1)
				acc_q.match_count <= acc_q.match_count + 1'b1;
			acc_q.volume_sum   <= vol_add[trva_pkg::SumW] ? '1 : vol_add[trva_pkg::SumW-1:0];
			acc_q.price_sum    <= price_add[trva_pkg::SumW] ? '1
				: price_add[trva_pkg::SumW-1:0];
			acc_q.weighted_sum <= wsum_add[trva_pkg::SumW] ? '1 : wsum_add[trva_pkg::SumW-1:0];
			if (acc_q.first_pending) begin
				acc_q.min_seen      <= price_q;
				acc_q.max_seen      <= price_q;
				acc_q.first_pending <= 1'b0;
			end else begin
				if (price_q < acc_q.min_seen)
					acc_q.min_seen <= price_q;
				if (price_q > acc_q.max_seen)
					acc_q.max_seen <= price_q;
			end
		end
	end

	assign acc = acc_q;

endmodule

FILE: hdl/tick_range_vwap_aggregate.sv
// ---------------------------------------------------------------------------
// tick_range_vwap_aggregate
// Filters ticks by timestamp window, accumulates count, volume, price and
// price x volume sums plus min/max price, and emits one summary per run.
// ---------------------------------------------------------------------------
// A tick that is not last passes accept, multiply and add before the next accept.
// A last tick also runs two divisions on one shared divider, each a start,
//   64 one-bit steps and a done, then the emit state registers the summary.
// Emit, and so the next accept, stalls while the previous summary still waits
//   on m_axis_tready.
// Reset (arst_n low, async): sequencer idle, accumulators cleared, output
//   invalid, range_start = 0, range_end = all ones.
module tick_range_vwap_aggregate (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write port
	input  logic                          cfg_we,
	input  logic [trva_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [trva_pkg::CfgW-1:0]     cfg_data,
	// tick input
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// timestamp[63:0], price[95:64], volume[127:96]
	input  logic [trva_pkg::InDataW-1:0]  s_axis_tdata,
	input  logic                          s_axis_tlast,
	// summary output
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tick_count[31:0], total_volume[95:32], average_price[127:96],
	// weighted_price[159:128], lowest_price[191:160], highest_price[223:192]
	output logic [trva_pkg::OutDataW-1:0] m_axis_tdata
);

	trva_pkg::trva_state_t state_q, state_d;

	logic [trva_pkg::TsW-1:0]    range_start_q;
	logic [trva_pkg::TsW-1:0]    range_end_q;
	logic                        last_q;
	logic [trva_pkg::PriceW-1:0] avg_q;
	logic [trva_pkg::PriceW-1:0] vwap_q;
	logic                        out_valid_q;
	logic [trva_pkg::OutDataW-1:0] out_data_q;

	trva_pkg::acc_ctl_t   acc_ctl;
	trva_pkg::acc_state_t acc_st;
	trva_pkg::div_stat_t  div_st;

	logic                      div_start;
	logic [trva_pkg::DivW-1:0] div_dividend;
	logic [trva_pkg::DivW-1:0] div_divisor;
	logic [trva_pkg::DivW-1:0] div_quotient;

	logic in_fire;
	logic emit_go;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	// output register is free, or is being drained this cycle
	assign emit_go = !out_valid_q || m_axis_tready;

	// ---------------- config registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q <= '0;
			range_end_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trva_pkg::CFG_RANGE_START: range_start_q <= cfg_data;
				trva_pkg::CFG_RANGE_END:   range_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= trva_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trva_pkg::ST_IDLE:      if (in_fire) state_d = trva_pkg::ST_MUL;
			trva_pkg::ST_MUL:       state_d = trva_pkg::ST_ACC;
			trva_pkg::ST_ACC:       state_d = last_q ? trva_pkg::ST_AVG_GO : trva_pkg::ST_IDLE;
			trva_pkg::ST_AVG_GO:    state_d = trva_pkg::ST_AVG_WAIT;
			trva_pkg::ST_AVG_WAIT:  if (div_st.done) state_d = trva_pkg::ST_VWAP_GO;
			trva_pkg::ST_VWAP_GO:   state_d = trva_pkg::ST_VWAP_WAIT;
			trva_pkg::ST_VWAP_WAIT: if (div_st.done) state_d = trva_pkg::ST_EMIT;
			trva_pkg::ST_EMIT:      if (emit_go) state_d = trva_pkg::ST_IDLE;
			default:                state_d = trva_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		acc_ctl       = '0;
		div_start     = 1'b0;
		div_dividend  = acc_st.price_sum;
		div_divisor   = trva_pkg::DivW'(acc_st.match_count);
		unique case (state_q)
			trva_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				acc_ctl.load  = in_fire;
			end
			trva_pkg::ST_MUL:  acc_ctl.mul = 1'b1;
			trva_pkg::ST_ACC:  acc_ctl.add = 1'b1;
			trva_pkg::ST_AVG_GO: div_start = 1'b1;
			trva_pkg::ST_VWAP_GO: begin
				div_start    = 1'b1;
				div_dividend = acc_st.weighted_sum;
				div_divisor  = acc_st.volume_sum;
			end
			trva_pkg::ST_EMIT: acc_ctl.clear = emit_go;
			default: ;
		endcase
	end

	// last flag of the tick in flight
	always_ff @(posedge clk) begin
		if (in_fire)
			last_q <= s_axis_tlast;
	end

	// quotient capture; zero divisor forces a zero field
	always_ff @(posedge clk) begin
		if (state_q == trva_pkg::ST_AVG_WAIT && div_st.done)
			avg_q <= (acc_st.match_count == '0) ? '0 : trva_pkg::sat_price(div_quotient);
		if (state_q == trva_pkg::ST_VWAP_WAIT && div_st.done)
			vwap_q <= (acc_st.volume_sum == '0) ? '0 : trva_pkg::sat_price(div_quotient);
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == trva_pkg::ST_EMIT && emit_go)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	// with no match all sums and min/max are still zero
	always_ff @(posedge clk) begin
		if (state_q == trva_pkg::ST_EMIT && emit_go)
			out_data_q <= {acc_st.max_seen, acc_st.min_seen, vwap_q, avg_q,
				acc_st.volume_sum, acc_st.match_count};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- units ----------------
	trva_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (acc_ctl),
		.timestamp   (s_axis_tdata[trva_pkg::TsW-1:0]),
		.price       (s_axis_tdata[trva_pkg::TsW +: trva_pkg::PriceW]),
		.volume      (s_axis_tdata[trva_pkg::TsW + trva_pkg::PriceW +: trva_pkg::VolW]),
		.range_start (range_start_q),
		.range_end   (range_end_q),
		.acc         (acc_st)
	);

	trva_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.status   (div_st)
	);

`ifndef SYNTHESIS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	a_no_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> !s_axis_tready)
		else $error("tick accepted during division");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == trva_pkg::ST_EMIT))
		else $error("output valid without emit");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == trva_pkg::ST_EMIT && emit_go) |=>
		(acc_st.match_count == '0 && acc_st.first_pending))
		else $error("accumulators not cleared after emit");
`endif

endmodule

FILE: tb/tb_tick_range_vwap_aggregate.sv
// ---------------------------------------------------------------------------
// tb_tick_range_vwap_aggregate
// Self-checking bench for the tick range VWAP aggregator. Ticks stream in
// through the slave bus in random bursts while the master side stalls on
// its own pattern. A local predictor folds every accepted tick into a copy of
// the running sums and queues one summary per last tick. Every summary that
// leaves the block is checked field by field against the oldest queued one.
// The window registers change only between phases, once the block is idle.
// ---------------------------------------------------------------------------
module tb_tick_range_vwap_aggregate;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ALL64    = '1;
	localparam logic [31:0] MAX32    = '1;
	localparam int          RND_TICKS  = 1200;
	// a non-last tick passes accept, multiply and add, so this margin covers any work in flight
	localparam int          SETTLE_CYC = 8;
	// a last tick runs two 64-step divisions before the next accept
	localparam int          DRAIN_CYC  = 200;
	// longest quiet stretch: division + master stall + sender gap, many times over
	localparam int          STALL_LIMIT = 4000;

	typedef struct {
		logic [63:0] ts;
		logic [31:0] price;
		logic [31:0] volume;
		logic        last;
	} tick_t;

	// same layout as m_axis_tdata, tick_count in the lowest bits
	typedef struct packed {
		logic [31:0] highest;
		logic [31:0] lowest;
		logic [31:0] vwap;
		logic [31:0] average;
		logic [63:0] volume;
		logic [31:0] count;
	} summary_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [trva_pkg::CfgIdxW-1:0]  cfg_index = trva_pkg::CFG_RANGE_START;
	logic [trva_pkg::CfgW-1:0]     cfg_data = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	// timestamp[63:0], price[95:64], volume[127:96]
	logic [trva_pkg::InDataW-1:0]  s_axis_tdata = '0;
	logic                          s_axis_tlast = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	// tick_count[31:0], total_volume[95:32], average_price[127:96],
	// weighted_price[159:128], lowest_price[191:160], highest_price[223:192]
	logic [trva_pkg::OutDataW-1:0] m_axis_tdata;

	tick_range_vwap_aggregate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ticks waiting to be sent, summaries waiting to come out
	tick_t    pending_ticks[$];
	summary_t due_summaries[$];
	int       fail_count = 0;
	int       queued_ticks = 0;

	// ---------------------------------------------------------------------
	// Predictor state: window copy (tracked off the config port) and sums
	// ---------------------------------------------------------------------
	logic [63:0] win_lo = '0;
	logic [63:0] win_hi = '1;
	logic [31:0] acc_count = '0;
	logic [63:0] acc_volume = '0;
	logic [63:0] acc_price = '0;
	logic [63:0] acc_weighted = '0;
	logic [31:0] acc_low = '0;
	logic [31:0] acc_high = '0;
	logic        acc_none = 1'b1;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL64 : s[63:0];
	endfunction

	function automatic logic [31:0] clamp32(input logic [63:0] v);
		return (v > {32'd0, MAX32}) ? MAX32 : v[31:0];
	endfunction

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	task automatic cmp_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got)
			flag($sformatf("summary %s mismatch: exp %h got %h", name, want, got));
	endtask

	// fold one accepted tick into the sums; a last tick closes the run
	task automatic fold_tick(input tick_t t);
		summary_t s;
		if (win_lo <= win_hi && t.ts >= win_lo && t.ts <= win_hi) begin
			if (acc_count != MAX32)
				acc_count++;
			acc_volume   = sat_add(acc_volume, {32'd0, t.volume});
			acc_price    = sat_add(acc_price, {32'd0, t.price});
			acc_weighted = sat_add(acc_weighted, 64'(t.price) * 64'(t.volume));
			if (acc_none) begin
				acc_low  = t.price;
				acc_high = t.price;
				acc_none = 1'b0;
			end else begin
				if (t.price < acc_low)
					acc_low = t.price;
				if (t.price > acc_high)
					acc_high = t.price;
			end
		end
		if (t.last) begin
			s = '0;
			// nothing matched leaves the whole summary at zero
			if (acc_count != 0) begin
				s.count   = acc_count;
				s.volume  = acc_volume;
				s.average = clamp32(acc_price / {32'd0, acc_count});
				s.vwap    = (acc_volume != 0) ? clamp32(acc_weighted / acc_volume) : '0;
				s.lowest  = acc_low;
				s.highest = acc_high;
			end
			due_summaries.insert(due_summaries.size(), s);
			acc_count    = '0;
			acc_volume   = '0;
			acc_price    = '0;
			acc_weighted = '0;
			acc_low      = '0;
			acc_high     = '0;
			acc_none     = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------------
	// Monitor: samples both buses and the config port at the rising edge
	// ---------------------------------------------------------------------
	logic     took_tick = 1'b0;
	int       idle_cycles = 0;
	tick_t    seen;
	summary_t got, want;

	always @(posedge clk) begin
		took_tick <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == trva_pkg::CFG_RANGE_START)
					win_lo = cfg_data;
				else
					win_hi = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen.ts     = s_axis_tdata[63:0];
				seen.price  = s_axis_tdata[95:64];
				seen.volume = s_axis_tdata[127:96];
				seen.last   = s_axis_tlast;
				fold_tick(seen);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = summary_t'(m_axis_tdata);
				if (due_summaries.size() == 0) begin
					flag($sformatf("summary with none pending: %h", m_axis_tdata));
				end else begin
					want = due_summaries.pop_front();
					cmp_field("tick_count", 64'(want.count), 64'(got.count));
					cmp_field("total_volume", want.volume, got.volume);
					cmp_field("average_price", 64'(want.average), 64'(got.average));
					cmp_field("weighted_price", 64'(want.vwap), 64'(got.vwap));
					cmp_field("lowest_price", 64'(want.lowest), 64'(got.lowest));
					cmp_field("highest_price", 64'(want.highest), 64'(got.highest));
				end
			end
			// watchdog: no handshake on either side for too long
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
					$display("tb_tick_range_vwap_aggregate: done, errors");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Driver: bursts of random length with random gaps, falling edge
	// ---------------------------------------------------------------------
	int    burst_left = 1;
	int    gap_left = 0;
	tick_t nxt;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || took_tick) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				nxt = pending_ticks.pop_front();
				s_axis_tdata  <= {nxt.volume, nxt.price, nxt.ts};
				s_axis_tlast  <= nxt.last;
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: stall mode picked at random and held for a while
	// ---------------------------------------------------------------------
	int       ready_mode = 0;
	int       mode_left = 0;
	int       rx_cyc = 0;

	always @(negedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= (rx_cyc % 8 == 0);
			default: m_axis_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	logic [63:0] cur_lo = '0;
	logic [63:0] cur_hi = '1;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic queue_tick(input logic [63:0] ts, input logic [31:0] price,
			input logic [31:0] volume, input logic last);
		tick_t t;
		t.ts = ts;
		t.price = price;
		t.volume = volume;
		t.last = last;
		pending_ticks.insert(pending_ticks.size(), t);
		queued_ticks++;
	endtask

	// wait until every tick is sent and every summary is back
	task automatic settle();
		do
			@(posedge clk);
		while (pending_ticks.size() != 0 || s_axis_tvalid || due_summaries.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_window(input logic [63:0] lo, input logic [63:0] hi);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= trva_pkg::CFG_RANGE_START;
		cfg_data  <= lo;
		@(negedge clk);
		cfg_index <= trva_pkg::CFG_RANGE_END;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	// mostly inside the window, some just outside its edges, some anywhere
	function automatic logic [63:0] pick_ts();
		logic [63:0] span;
		int          r;
		r = $urandom_range(0, 9);
		span = cur_hi - cur_lo;
		if (r <= 5) begin
			if (cur_lo > cur_hi || span == ALL64)
				return rand64();
			return cur_lo + rand64() % (span + 1);
		end
		case (r)
			6: return cur_lo - 1;
			7: return cur_hi + 1;
			8: return ($urandom_range(0, 1) != 0) ? cur_lo : cur_hi;
			default: return rand64();
		endcase
	endfunction

	function automatic logic [31:0] pick_price();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MAX32;
			2: return $urandom_range(0, 32'h000F_FFFF);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_volume();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MAX32;
			2: return $urandom_range(0, 1000);
			default: return $urandom();
		endcase
	endfunction

	logic [63:0] lo, hi;
	int          runs, len;

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed, window at its reset value (everything matches) ---
		queue_tick(ALL64, MAX32, MAX32, 1'b1);          // all ones, single-tick run
		queue_tick(64'd0, 32'd0, 32'd0, 1'b1);           // zero volume: vwap stays 0
		queue_tick(64'd5, MAX32, MAX32, 1'b0);           // weighted sum saturates
		queue_tick(64'd6, MAX32, MAX32, 1'b0);
		queue_tick(64'd7, 32'd1, 32'd2, 1'b1);
		queue_tick(64'd1, 32'h0001_0000, 32'd3, 1'b0);   // min/max tracking
		queue_tick(64'd2, 32'h0003_0000, 32'd0, 1'b0);
		queue_tick(64'd3, 32'h0000_8000, 32'd5, 1'b1);
		settle();

		// window edges; the last tick itself falls outside
		write_window(64'd100, 64'd200);
		queue_tick(64'd99, 32'h0002_0000, 32'd7, 1'b0);
		queue_tick(64'd100, 32'h0004_0000, 32'd9, 1'b0);
		queue_tick(64'd200, 32'h0001_8000, 32'd11, 1'b0);
		queue_tick(64'd201, 32'h0009_0000, 32'd13, 1'b1);
		// nothing matched
		queue_tick(64'd50, 32'h0001_0000, 32'd1, 1'b0);
		queue_tick(64'd300, 32'h0001_0000, 32'd1, 1'b1);
		settle();

		// start above end: empty window
		write_window(64'd300, 64'd200);
		queue_tick(64'd250, 32'h0005_0000, 32'd4, 1'b0);
		queue_tick(64'd200, 32'h0006_0000, 32'd4, 1'b1);
		settle();

		write_window(ALL64, ALL64);
		queue_tick(ALL64, 32'h1234_5678, 32'd10, 1'b1);
		queue_tick(ALL64 - 1, 32'h1234_5678, 32'd10, 1'b1);
		settle();

		write_window(64'd0, 64'd0);
		queue_tick(64'd0, 32'h0000_0001, MAX32, 1'b0);
		queue_tick(64'd1, MAX32, 32'd1, 1'b1);
		settle();

		// --- random phases: new window, then a handful of runs ---
		queued_ticks = 0;
		while (queued_ticks < RND_TICKS) begin
			case ($urandom_range(0, 5))
				0: begin
					lo = '0;
					hi = ALL64;
				end
				1: begin
					lo = rand64();
					hi = (lo > ALL64 - 1000) ? ALL64 : lo + $urandom_range(0, 1000);
				end
				2: begin
					lo = rand64();
					hi = rand64();
				end
				3: begin
					lo = rand64() | 64'd1;
					hi = lo - 1;
				end
				4: begin
					lo = rand64();
					hi = lo;
				end
				default: begin
					lo = ALL64 - $urandom_range(0, 500);
					hi = ALL64;
				end
			endcase
			write_window(lo, hi);
			runs = $urandom_range(1, 8);
			repeat (runs) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
				for (int i = 0; i < len; i++)
					queue_tick(pick_ts(), pick_price(), pick_volume(), i == len - 1);
			end
			settle();
		end

		repeat (DRAIN_CYC) @(posedge clk);
		if (due_summaries.size() != 0)
			flag($sformatf("%0d summaries never arrived", due_summaries.size()));
		if (fail_count == 0) begin
			$display("tb_tick_range_vwap_aggregate: done, clean");
		end else begin
			$display("tb_tick_range_vwap_aggregate: done, errors");
		end
		$finish;
	end

endmodule
